// ===== hw/rtl/mipd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mipd_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_BOX_X = 2'd0;
	localparam logic [1:0] REG_BOX_Y = 2'd1;
	localparam logic [1:0] REG_BOX_Z = 2'd2;

	localparam int          BOX_W     = 31;
	localparam int          DELTA_W   = 32;
	localparam int          ANGLE_W   = 18;
	localparam logic [30:0] BOX_RESET = 31'd6553600;

	// Pi with 32 fraction bits, rounded to nearest.
	localparam logic [63:0] PI_Q32 = 64'd13493037705;

	typedef struct packed {
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
		logic signed [DELTA_W-1:0] delta_z;
	} item_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQ,
		B_CHECK,
		B_CAND,
		B_APPLY,
		B_NORM,
		B_ROT,
		B_FIN
	} back_state_t;

	// atan(2^-i) in radians with 32 fraction bits, rounded to nearest.
	function automatic logic [31:0] atan_q32(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:    r = 32'hC90FDAA2;
			5'd1:    r = 32'h76B19C16;
			5'd2:    r = 32'h3EB6EBF2;
			5'd3:    r = 32'h1FD5BA9B;
			5'd4:    r = 32'h0FFAADDC;
			5'd5:    r = 32'h07FF556F;
			5'd6:    r = 32'h03FFEAAB;
			5'd7:    r = 32'h01FFFD55;
			5'd8:    r = 32'h00FFFFAB;
			5'd9:    r = 32'h007FFFF5;
			5'd10:   r = 32'h003FFFFF;
			default: r = 32'd1 << (6'd32 - {1'b0, i});
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mipd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mipd_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire mipd_pkg::item_t  in_item,
	output logic                  q_valid,
	output mipd_pkg::item_t       q_item,
	input  wire                   q_pop
);
	import mipd_pkg::*;

	// Two-entry queue that decouples intake from the folding engine.
	item_t      mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0) else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count missed a push");
endmodule
`default_nettype wire

// ===== hw/rtl/mipd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mipd_back #(
	parameter int MAX_WRAP_STEPS = 16,
	parameter int CORDIC_STEPS   = 18,
	parameter int FRAC_BITS      = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire [mipd_pkg::BOX_W-1:0] box_x,
	input  wire [mipd_pkg::BOX_W-1:0] box_y,
	input  wire [mipd_pkg::BOX_W-1:0] box_z,
	input  wire                       q_valid,
	input  wire mipd_pkg::item_t      q_item,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic [17:0]               angle_from_cosine,
	output logic signed [17:0]        angle_from_sine,
	output logic                      no_direction,
	output logic                      wrap_limit_hit
);
	import mipd_pkg::*;

	localparam int SW = $clog2(MAX_WRAP_STEPS + 1);
	localparam int RW = $clog2(CORDIC_STEPS);
	localparam logic signed [35:0] RND =
		36'(64'd1 << (31 - FRAC_BITS));
	localparam logic signed [35:0] PI_OUT =
		36'((PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
	localparam logic signed [35:0] HALF_OUT =
		36'((PI_Q32 + (64'd1 << (32 - FRAC_BITS))) >> (33 - FRAC_BITS));

	back_state_t state_q, state_d;

	logic signed [33:0] vx_q, vy_q, vz_q;
	logic signed [68:0] len_q;
	logic        [61:0] minb2_q;
	logic signed [69:0] prod_q;
	logic signed [69:0] best_d_q;
	logic        [2:0]  best_idx_q;
	logic        [2:0]  cnt_q;
	logic      [SW-1:0] steps_q;
	logic               limit_q, nodir_q, same_q;
	logic signed [42:0] x_q, y_q;
	logic signed [35:0] z_q;
	logic      [RW-1:0] rot_q;

	logic [BOX_W-1:0]   minb;
	logic [32:0]        mul_a;
	logic signed [35:0] mul_b;
	logic signed [69:0] product;
	logic               too_long;
	logic [BOX_W-1:0]   cand_box;
	logic signed [33:0] cand_v;
	logic signed [42:0] mx, xs, ys;
	logic signed [35:0] theta_raw, theta;
	logic               out_free;

	function automatic logic [32:0] mag34(input logic signed [33:0] v);
		return v[33] ? 33'(-v) : 33'(v);
	endfunction

	always_comb begin
		minb = box_x;
		if (box_y < minb) minb = box_y;
		if (box_z < minb) minb = box_z;
	end

	// Candidate translation: component cnt[2:1], minus when cnt[0] is set.
	always_comb begin
		case (cnt_q[2:1])
			2'd0:    begin cand_box = box_x; cand_v = vx_q; end
			2'd1:    begin cand_box = box_y; cand_v = vy_q; end
			default: begin cand_box = box_z; cand_v = vz_q; end
		endcase
	end

	// One shared multiplier: squares of the components, the squared limit,
	// then the length change b*(b +/- 2v) of each candidate.
	always_comb begin
		mul_a = 33'(minb);
		mul_b = 36'(minb);
		if (state_q == B_SQ) begin
			case (cnt_q)
				3'd0:    begin mul_a = mag34(vx_q); mul_b = 36'(mag34(vx_q)); end
				3'd1:    begin mul_a = mag34(vy_q); mul_b = 36'(mag34(vy_q)); end
				3'd2:    begin mul_a = mag34(vz_q); mul_b = 36'(mag34(vz_q)); end
				default: begin mul_a = 33'(minb); mul_b = 36'(minb); end
			endcase
		end else if (state_q == B_CAND) begin
			mul_a = 33'(cand_box);
			mul_b = cnt_q[0] ? 36'(cand_box) - (36'(cand_v) <<< 1)
			                 : 36'(cand_box) + (36'(cand_v) <<< 1);
		end
	end

	assign product  = 70'($signed({1'b0, mul_a}) * mul_b);
	assign too_long = $signed({len_q, 2'b00}) > $signed({9'b0, minb2_q});
	assign mx       = (x_q > y_q) ? x_q : y_q;
	assign xs       = x_q >>> rot_q;
	assign ys       = y_q >>> rot_q;
	assign theta_raw = (z_q + RND) >>> (32 - FRAC_BITS);
	assign out_free = !out_valid || !out_stall;
	assign q_pop    = (state_q == B_IDLE) && q_valid;

	always_comb begin
		theta = theta_raw;
		if (theta_raw < 0) theta = '0;
		else if (theta_raw > HALF_OUT) theta = HALF_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (q_valid) state_d = B_SQ;
			B_SQ:    if (cnt_q == 3'd4) state_d = B_CHECK;
			B_CHECK: begin
				if (!too_long || steps_q == SW'(MAX_WRAP_STEPS)) state_d = B_NORM;
				else state_d = B_CAND;
			end
			B_CAND:  if (cnt_q == 3'd6) state_d = B_APPLY;
			B_APPLY: state_d = (best_d_q < 0) ? B_CHECK : B_NORM;
			B_NORM: begin
				if (nodir_q) state_d = B_FIN;
				else if (mx >= 43'sd549755813888) state_d = B_ROT;
			end
			B_ROT:   if (rot_q == RW'(CORDIC_STEPS - 1)) state_d = B_FIN;
			B_FIN:   if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Datapath registers; prod_q loads the product every cycle, the others hold outside the states that write them.
	always_ff @(posedge clk) begin
		prod_q <= product;
		unique case (state_q)
			B_IDLE: begin
				vx_q  <= 34'(q_item.delta_x);
				vy_q  <= 34'(q_item.delta_y);
				vz_q  <= 34'(q_item.delta_z);
				len_q <= '0;
				cnt_q <= '0;
			end
			B_SQ: begin
				if (cnt_q != 3'd0 && cnt_q != 3'd4) len_q <= len_q + prod_q[68:0];
				if (cnt_q == 3'd4) minb2_q <= prod_q[61:0];
				cnt_q <= cnt_q + 3'd1;
			end
			B_CHECK: begin
				best_d_q   <= '0;
				best_idx_q <= '0;
				cnt_q      <= '0;
				x_q        <= 43'(mag34(vx_q));
				y_q        <= 43'(mag34(vy_q));
				nodir_q    <= (vx_q == 0) && (vy_q == 0);
				same_q     <= (vx_q > 0 && vy_q > 0) || (vx_q < 0 && vy_q < 0);
			end
			B_CAND: begin
				if (cnt_q != 3'd0 && prod_q < best_d_q) begin
					best_d_q   <= prod_q;
					best_idx_q <= cnt_q - 3'd1;
				end
				cnt_q <= cnt_q + 3'd1;
			end
			B_APPLY: begin
				if (best_d_q < 0) begin
					len_q <= len_q + best_d_q[68:0];
					case (best_idx_q)
						3'd0:    vx_q <= vx_q + 34'(box_x);
						3'd1:    vx_q <= vx_q - 34'(box_x);
						3'd2:    vy_q <= vy_q + 34'(box_y);
						3'd3:    vy_q <= vy_q - 34'(box_y);
						3'd4:    vz_q <= vz_q + 34'(box_z);
						default: vz_q <= vz_q - 34'(box_z);
					endcase
				end
			end
			B_NORM: begin
				z_q <= '0;
				if (mx < 43'sd4294967296) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (mx < 43'sd549755813888) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			B_ROT: begin
				if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + 36'(atan_q32(5'(rot_q)));
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - 36'(atan_q32(5'(rot_q)));
				end
			end
			B_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= '0;
			limit_q   <= 1'b0;
			rot_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == B_IDLE) begin
				steps_q <= '0;
				limit_q <= 1'b0;
			end
			if (state_q == B_CHECK && too_long && steps_q == SW'(MAX_WRAP_STEPS)) begin
				limit_q <= 1'b1;
			end
			if (state_q == B_APPLY && best_d_q < 0) begin
				steps_q <= steps_q + SW'(1);
			end
			if (state_q == B_ROT) rot_q <= rot_q + RW'(1);
			else rot_q <= '0;
			if (state_q == B_FIN && out_free) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_FIN && out_free) begin
			no_direction   <= nodir_q;
			wrap_limit_hit <= limit_q;
			if (nodir_q) begin
				angle_from_cosine <= '0;
				angle_from_sine   <= '0;
			end else if (same_q) begin
				angle_from_cosine <= theta[17:0];
				angle_from_sine   <= theta[17:0];
			end else begin
				angle_from_cosine <= 18'(PI_OUT - theta);
				angle_from_sine   <= 18'(-theta);
			end
		end
	end

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= SW'(MAX_WRAP_STEPS)) else $error("wrap step count overran");
	a_rot_has_dir: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_ROT |-> !nodir_q) else $error("rotation on zero vector");
	a_limit_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FIN && limit_q) |-> steps_q == SW'(MAX_WRAP_STEPS))
		else $error("limit flag without full step count");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == B_SQ) else $error("pop did not start an item");
endmodule
`default_nettype wire

// ===== hw/rtl/min_image_planar_direction_angle_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_stall     delta_x, delta_y, delta_z
// out       source     out_valid / out_stall   angle_from_cosine, angle_from_sine,
//                                              no_direction, wrap_limit_hit
// cfg       sink       cfg_we                  cfg_index, cfg_data
//
// Each vector leaves the queue, goes through squaring and one length check,
// then through a candidate search plus the next check for each applied box
// translation. When no candidate is shorter, the last search still runs in
// full. Then come normalizing, CORDIC_STEPS rotation steps (none for a zero
// planar direction) and the finish. The shared multiplier and the single
// CORDIC stage make this work sequential.
// Reset (arst_n low) empties the queue, drops out_valid and sets each box edge
// to 100.0. The two-entry queue takes new transactions while the engine works,
// and a finished result waits in the output register while out_stall is high.
module min_image_planar_direction_angle_core #(
	parameter int MAX_WRAP_STEPS = 16,
	parameter int CORDIC_STEPS   = 18,
	parameter int FRAC_BITS      = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire signed [31:0]   delta_x,
	input  wire signed [31:0]   delta_y,
	input  wire signed [31:0]   delta_z,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [17:0]         angle_from_cosine,
	output logic signed [17:0]  angle_from_sine,
	output logic                no_direction,
	output logic                wrap_limit_hit,
	input  wire                 cfg_we,
	input  wire [1:0]           cfg_index,
	input  wire [30:0]          cfg_data
);
	import mipd_pkg::*;

	// Box edge registers; the user must change configuration only while the block is idle (not enforced here).
	logic [BOX_W-1:0] box_x_q, box_y_q, box_z_q;
	item_t            in_item, q_item;
	logic             q_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= BOX_RESET;
			box_y_q <= BOX_RESET;
			box_z_q <= BOX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_X: box_x_q <= cfg_data;
				REG_BOX_Y: box_y_q <= cfg_data;
				REG_BOX_Z: box_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_item.delta_x = delta_x;
	assign in_item.delta_y = delta_y;
	assign in_item.delta_z = delta_z;

	// The front end only queues transactions; all folding and angle work
	// happens in the back end, one vector at a time.
	mipd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	mipd_back #(
		.MAX_WRAP_STEPS (MAX_WRAP_STEPS),
		.CORDIC_STEPS   (CORDIC_STEPS),
		.FRAC_BITS      (FRAC_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.box_x             (box_x_q),
		.box_y             (box_y_q),
		.box_z             (box_z_q),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.angle_from_cosine (angle_from_cosine),
		.angle_from_sine   (angle_from_sine),
		.no_direction      (no_direction),
		.wrap_limit_hit    (wrap_limit_hit)
	);
endmodule
`default_nettype wire
